/* rtl/key_scan_debounce_to_midi_notes_core_defines.svh */
// Assertion macros shared by the key scan debounce RTL.
`ifndef KEY_SCAN_DEBOUNCE_TO_MIDI_NOTES_CORE_DEFINES_SVH
`define KEY_SCAN_DEBOUNCE_TO_MIDI_NOTES_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define KSD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ksd invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define KSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksd implication violated");

`endif

/* rtl/ksd_pkg.sv */
// Shared types, constants and helper functions of the key scan debounce block.
`default_nettype none

package ksd_pkg;

  localparam int unsigned KEY_MASK_W = 14;
  localparam int unsigned NOTE_KEYS  = 12;
  localparam int unsigned KEY_DOWN   = 12;
  localparam int unsigned KEY_UP     = 13;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [6:0] OCT_MIN   = 7'd24;
  localparam logic [6:0] OCT_MAX   = 7'd96;
  localparam logic [6:0] OCT_STEP  = 7'd12;
  localparam logic [6:0] OCT_RESET = 7'd60;

  localparam logic [7:0] THRESH_RESET = 8'd50;
  localparam logic [7:0] CNT_MAX      = 8'd255;
  localparam logic [6:0] VEL_RESET    = 7'd100;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_IDX_VELOCITY  = 2'd1;
  localparam logic [1:0] CFG_IDX_OCTAVE    = 2'd2;

  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_OCTAVE   = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [5:0] down;
    logic [5:0] up;
  } led_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [6:0] note;
    logic [6:0] vel;
    logic [5:0] down;
    logic [5:0] up;
    logic       last;
  } event_t;

  function automatic logic [6:0] clamp_octave(input logic [6:0] v);
    logic [6:0] r;
    if (v < OCT_MIN) begin
      r = OCT_MIN;
    end else if (v > OCT_MAX) begin
      r = OCT_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic led_t led_levels(input logic [6:0] oct);
    led_t l;
    l = '0;
    unique case (oct)
      7'd24:   l.down = 6'd60;
      7'd36:   l.down = 6'd40;
      7'd48:   l.down = 6'd20;
      7'd72:   l.up   = 6'd20;
      7'd84:   l.up   = 6'd40;
      7'd96:   l.up   = 6'd60;
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

/* rtl/ksd_front.sv */
// Front end: debounces scans and turns a stable change into a queued job.
`default_nettype none

module ksd_front
  import ksd_pkg::*;
#(
  parameter int unsigned SCAN_W = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_wr_t               cfg,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SCAN_W-1:0]     scan,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [2*SCAN_W-1:0]        q_job
);

  logic [SCAN_W-1:0] prev_r, prev_nxt;
  logic [SCAN_W-1:0] sent_r, sent_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        thresh_r, thresh_nxt;

  logic              accept;
  logic              equal;
  logic              fire;
  logic [7:0]        cnt_inc;
  logic [SCAN_W-1:0] emit;

  always_comb begin
    in_tready = !q_full;
    accept    = in_tvalid && in_tready;
    equal     = (scan == prev_r);
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;
    fire      = equal && (cnt_inc > thresh_r);

    // Releases of the octave keys produce nothing, so they are dropped here.
    for (int i = 0; i < int'(SCAN_W); i++) begin
      emit[i] = (scan[i] ^ sent_r[i]) && ((i < int'(NOTE_KEYS)) || scan[i]);
    end

    prev_nxt   = prev_r;
    sent_nxt   = sent_r;
    cnt_nxt    = cnt_r;
    thresh_nxt = thresh_r;
    q_push     = 1'b0;

    if (accept) begin
      prev_nxt = scan;
      if (!equal || fire) begin
        cnt_nxt = 8'd0;
      end else begin
        cnt_nxt = cnt_inc;
      end
      if (fire) begin
        sent_nxt = scan;
        q_push   = (emit != '0);
      end
    end

    if (cfg.we && (cfg.index == CFG_IDX_THRESHOLD)) begin
      thresh_nxt = cfg.data;
    end

    q_job = {scan, emit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      sent_r   <= '0;
      cnt_r    <= '0;
      thresh_r <= THRESH_RESET;
    end else begin
      prev_r   <= prev_nxt;
      sent_r   <= sent_nxt;
      cnt_r    <= cnt_nxt;
      thresh_r <= thresh_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ksd_queue.sv */
// Small job queue between the debounce front end and the event serializer.
`default_nettype none
`include "key_scan_debounce_to_midi_notes_core_defines.svh"

module ksd_queue #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    full    = (count_r == CW'(DEPTH));
    empty   = (count_r == '0);
    rd_data = slot_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end

    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  `KSD_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH))
  `KSD_ASSERT_IMPLY(a_no_overflow, push && !pop, !full)

endmodule

`default_nettype wire

/* rtl/ksd_back.sv */
// Back end: walks the changed keys of a job and emits one event per cycle while out_tready is high.
`default_nettype none
`include "key_scan_debounce_to_midi_notes_core_defines.svh"

module ksd_back
  import ksd_pkg::*;
#(
  parameter int unsigned SCAN_W = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_wr_t               cfg,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire logic [2*SCAN_W-1:0]   q_job,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output event_t                     out_ev
);

  logic              busy_r, busy_nxt;
  logic [SCAN_W-1:0] work_r, work_nxt;
  logic [SCAN_W-1:0] press_r, press_nxt;
  logic [6:0]        oct_r, oct_nxt;
  logic [6:0]        vel_r, vel_nxt;
  logic              out_valid_r, out_valid_nxt;
  event_t            out_ev_r, out_ev_nxt;

  logic [SCAN_W-1:0] lowbit;
  logic [SCAN_W-1:0] rest;
  logic [3:0]        idx;
  logic              is_note, is_down, is_up, pressed;
  logic              step, last_ev;
  logic [6:0]        oct_down, oct_up, new_oct;
  led_t              leds;

  always_comb begin
    // Isolate the lowest pending key so events go out from key 0 upward.
    lowbit  = work_r & (~work_r + SCAN_W'(1));
    rest    = work_r & ~lowbit;
    pressed = |(lowbit & press_r);
    idx     = '0;
    is_note = 1'b0;
    is_down = 1'b0;
    is_up   = 1'b0;
    for (int i = 0; i < int'(SCAN_W); i++) begin
      if (lowbit[i]) begin
        idx = 4'(i);
        if (i < int'(NOTE_KEYS)) begin
          is_note = 1'b1;
        end else if (i == int'(KEY_DOWN)) begin
          is_down = 1'b1;
        end else if (i == int'(KEY_UP)) begin
          is_up = 1'b1;
        end
      end
    end

    oct_down = (oct_r < OCT_MIN + OCT_STEP) ? OCT_MIN : oct_r - OCT_STEP;
    oct_up   = clamp_octave(oct_r + OCT_STEP);
    new_oct  = is_down ? oct_down : (is_up ? oct_up : oct_r);
    leds     = led_levels(new_oct);

    step    = busy_r && (!out_valid_r || out_tready);
    last_ev = (rest == '0);
    q_pop   = !q_empty && (!busy_r || (step && last_ev));

    out_ev_nxt = out_ev_r;
    if (step) begin
      if (is_note) begin
        out_ev_nxt.kind = pressed ? EV_NOTE_ON : EV_NOTE_OFF;
        out_ev_nxt.note = {3'b000, idx} + oct_r;
        out_ev_nxt.vel  = pressed ? vel_r : 7'd0;
        out_ev_nxt.down = 6'd0;
        out_ev_nxt.up   = 6'd0;
      end else begin
        out_ev_nxt.kind = EV_OCTAVE;
        out_ev_nxt.note = 7'd0;
        out_ev_nxt.vel  = 7'd0;
        out_ev_nxt.down = leds.down;
        out_ev_nxt.up   = leds.up;
      end
      out_ev_nxt.last = last_ev;
    end
    out_valid_nxt = step || (out_valid_r && !out_tready);

    busy_nxt  = busy_r;
    work_nxt  = work_r;
    press_nxt = press_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      work_nxt  = q_job[SCAN_W-1:0];
      press_nxt = q_job[2*SCAN_W-1:SCAN_W];
    end else if (step) begin
      busy_nxt = !last_ev;
      work_nxt = rest;
    end

    oct_nxt = oct_r;
    vel_nxt = vel_r;
    if (cfg.we && (cfg.index == CFG_IDX_OCTAVE)) begin
      oct_nxt = clamp_octave(cfg.data[6:0]);
    end else if (step) begin
      oct_nxt = new_oct;
    end
    if (cfg.we && (cfg.index == CFG_IDX_VELOCITY)) begin
      vel_nxt = cfg.data[6:0];
    end

    out_tvalid = out_valid_r;
    out_ev     = out_ev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      oct_r       <= OCT_RESET;
      vel_r       <= VEL_RESET;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      oct_r       <= oct_nxt;
      vel_r       <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    press_r  <= press_nxt;
    out_ev_r <= out_ev_nxt;
  end

  `KSD_ASSERT_IMPLY(a_busy_has_work, busy_r, work_r != '0)
  `KSD_ASSERT_ALWAYS(a_octave_range, (oct_r >= OCT_MIN) && (oct_r <= OCT_MAX))

endmodule

`default_nettype wire

/* rtl/key_scan_debounce_to_midi_notes_core.sv */
// Top level of the key scan debounce to MIDI note event block.
//
// The in_ stream carries one key scan per beat. The block debounces it and,
// once the scan has been stable long enough, emits one out_ beat for each
// changed key but a released octave key, key 0 first; out_tlast marks the
// last beat of that scan. A new scan is accepted every cycle while the job
// queue has room; scans that cause no events only update the debounce state.
// An accepted scan goes through the job queue into the serializer, whose
// output register holds each event; events follow one per cycle while
// out_tready is high (at most 14 per scan); the single event serializer sets
// that rate, and an idle serializer first loads a job before its first event.
// When out_tready is low the current event is held and the serializer
// stops; the queue then fills and in_tready drops.
// Reset clears the debounce state, the queue and the output valid flag and
// loads the registers with threshold 50, velocity 100 and octave 60.
// A write to register 2 also reloads the current octave (clamped to 24..96).
`default_nettype none

module key_scan_debounce_to_midi_notes_core
  import ksd_pkg::*;
#(
  parameter int unsigned NUM_KEYS    = 14,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // key_mask[13:0], zero pad
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // event_kind[1:0], note_number[8:2], velocity[15:9], down_led_level[21:16],
  // up_led_level[27:22], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_wdata
);

  localparam int unsigned SCAN_W = (NUM_KEYS < KEY_MASK_W) ? NUM_KEYS : KEY_MASK_W;

  cfg_wr_t             cfg;
  logic                q_push, q_pop, q_full, q_empty;
  logic [2*SCAN_W-1:0] job_in, job_out;
  event_t              ev;

  always_comb begin
    cfg.we    = cfg_we;
    cfg.index = cfg_index;
    cfg.data  = cfg_wdata;
  end

  ksd_front #(
    .SCAN_W (SCAN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .scan      (in_tdata[SCAN_W-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (job_in)
  );

  ksd_queue #(
    .WIDTH (2 * SCAN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (job_in),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (job_out),
    .empty   (q_empty)
  );

  ksd_back #(
    .SCAN_W (SCAN_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_job      (job_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_ev     (ev)
  );

  assign out_tdata = {4'b0000, ev.up, ev.down, ev.vel, ev.note, ev.kind};
  assign out_tlast = ev.last;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for the key scan debouncer: a directed table, then random scan phases.
`timescale 1ns / 1ps

module tb_top
  import ksd_pkg::*;
();

  localparam int unsigned HALF_PERIOD_NS  = 6;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned LIMIT_CYCLES    = 1500000;
  localparam int unsigned NUM_PHASES      = 10;
  localparam logic [1:0]  CFG_IDX_SPARE   = 2'd3;
  localparam logic [13:0] ALL_KEYS        = 14'h3FFF;
  localparam logic [13:0] OCT_DOWN_KEY    = 14'h1000;
  localparam logic [13:0] OCT_UP_KEY      = 14'h2000;

  typedef enum logic { ROW_CFG, ROW_SCAN } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [7:0]  val;
    logic [13:0] mask;
    int          reps;
    bit          typed;
    event_t      ev;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // key_mask[13:0], zero pad
  logic                   out_tvalid;
  logic                   out_tready;
  // event_kind[1:0], note_number[8:2], velocity[15:9], down_led_level[21:16],
  // up_led_level[27:22], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [7:0]             cfg_wdata;

  // Debounce state and registers as the bench believes them to be.
  logic [13:0] prev_scan;
  logic [13:0] sent_keys;
  logic [7:0]  stable_cnt;
  logic [6:0]  cur_oct;
  logic [7:0]  thr_reg;
  logic [6:0]  vel_reg;
  logic [6:0]  oct_reg;

  event_t    fresh_events[$];
  event_t    pending_events[$];
  stim_row_t plan[$];
  event_t    got_ev;
  event_t    want_ev;

  int err_count     = 0;
  int beats_checked = 0;
  int scans_sent    = 0;
  int cfg_writes    = 0;
  bit calm          = 1'b0;
  bit gappy         = 1'b1;
  bit hold_off_req  = 1'b0;

  int unsigned phase_thr [NUM_PHASES] = '{0, 1, 2, 3, 0, 8, 20, 1, 0, 2};
  int unsigned phase_vel [NUM_PHASES] = '{127, 1, 64, 100, 0, 90, 33, 77, 50, 127};
  int unsigned phase_oct [NUM_PHASES] = '{96, 24, 36, 60, 61, 84, 72, 0, 255, 48};
  int unsigned phase_seqs[NUM_PHASES] = '{14, 10, 8, 6, 8, 2, 1, 10, 10, 10};

  key_scan_debounce_to_midi_notes_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #HALF_PERIOD_NS clk = 1'b1;
    #HALF_PERIOD_NS clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                beats_checked, name, got, want));
    end
  endtask

  function automatic event_t mk_event(input ev_kind_t kind, input int note, input int vel,
                                      input int down, input int up);
    event_t ev;
    ev      = '0;
    ev.kind = kind;
    ev.note = 7'(note);
    ev.vel  = 7'(vel);
    ev.down = 6'(down);
    ev.up   = 6'(up);
    ev.last = 1'b1;
    return ev;
  endfunction

  // Works out the events one accepted scan produces and advances the state.
  task automatic debounce_scan(input logic [13:0] scan);
    event_t ev;
    int     k;
    fresh_events.delete();
    if (scan == prev_scan) begin
      if (stable_cnt != CNT_MAX) stable_cnt = stable_cnt + 8'd1;
      if (stable_cnt > thr_reg) begin
        stable_cnt = '0;
        if (scan != sent_keys) begin
          for (k = 0; k < KEY_MASK_W; k++) begin
            if (scan[k] != sent_keys[k]) begin
              ev = '0;
              if (k < NOTE_KEYS) begin
                ev.kind = scan[k] ? EV_NOTE_ON : EV_NOTE_OFF;
                ev.note = cur_oct + 7'(k);
                ev.vel  = scan[k] ? vel_reg : 7'd0;
                fresh_events.push_back(ev);
              end else if (scan[k]) begin
                if (k == KEY_DOWN) begin
                  cur_oct = (cur_oct < OCT_MIN + OCT_STEP) ? OCT_MIN : cur_oct - OCT_STEP;
                end else begin
                  cur_oct = (cur_oct + OCT_STEP > OCT_MAX) ? OCT_MAX : cur_oct + OCT_STEP;
                end
                ev.kind = EV_OCTAVE;
                case (cur_oct)
                  7'd24:   ev.down = 6'd60;
                  7'd36:   ev.down = 6'd40;
                  7'd48:   ev.down = 6'd20;
                  7'd72:   ev.up   = 6'd20;
                  7'd84:   ev.up   = 6'd40;
                  7'd96:   ev.up   = 6'd60;
                  default: ev.up   = 6'd0;
                endcase
                fresh_events.push_back(ev);
              end
            end
          end
          sent_keys = scan;
        end
      end
    end else begin
      stable_cnt = '0;
    end
    prev_scan = scan;
    if (fresh_events.size() > 0) begin
      ev      = fresh_events.pop_back();
      ev.last = 1'b1;
      fresh_events.push_back(ev);
    end
  endtask

  // Offers one scan and records what it should produce once it is accepted.
  task automatic send_scan(input logic [13:0] mask, input bit typed, input event_t typed_ev);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - KEY_MASK_W){1'b0}}, mask};
    do @(posedge clk); while (in_tready !== 1'b1);
    debounce_scan(mask);
    scans_sent++;
    if (typed) begin
      pending_events.push_back(typed_ev);
    end else begin
      foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
    end
  endtask

  task automatic pace_sender();
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Waits until every expected event has come out and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_IDX_THRESHOLD: thr_reg = val;
      CFG_IDX_VELOCITY:  vel_reg = val[6:0];
      CFG_IDX_OCTAVE: begin
        oct_reg = val[6:0];
        cur_oct = (oct_reg < OCT_MIN) ? OCT_MIN : (oct_reg > OCT_MAX) ? OCT_MAX : oct_reg;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
    stim_row_t row;
    row      = '{kind: ROW_CFG, idx: idx, val: val, mask: '0, reps: 0, typed: 1'b0, ev: '0};
    plan.push_back(row);
  endtask

  task automatic add_scan(input logic [13:0] mask, input int reps);
    stim_row_t row;
    row      = '{kind: ROW_SCAN, idx: '0, val: '0, mask: mask, reps: reps, typed: 1'b0, ev: '0};
    plan.push_back(row);
  endtask

  task automatic add_checked(input logic [13:0] mask, input int reps, input event_t ev);
    stim_row_t row;
    row      = '{kind: ROW_SCAN, idx: '0, val: '0, mask: mask, reps: reps, typed: 1'b1, ev: ev};
    plan.push_back(row);
  endtask

  // One debounce episode: mostly a new mask held long enough to be sent,
  // sometimes a glitch that is too short, a repeat of the last scan, or noise.
  task automatic run_sequence();
    logic [13:0] target;
    int          pick;
    int          hold;
    int          n;
    pick = (thr_reg >= 8'd254) ? 0 : $urandom_range(0, 9);
    if (pick <= 6) begin
      case ((thr_reg >= 8'd254) ? 0 : $urandom_range(0, 4))
        0:       target = sent_keys ^ (14'd1 << $urandom_range(0, KEY_MASK_W - 1));
        1:       target = 14'($urandom);
        2:       target = sent_keys ^ (14'($urandom) & (OCT_DOWN_KEY | OCT_UP_KEY))
                          ^ (14'd1 << $urandom_range(0, NOTE_KEYS - 1));
        3:       target = $urandom_range(0, 1) ? ALL_KEYS : 14'h0000;
        default: target = sent_keys ^ (14'($urandom) & 14'($urandom));
      endcase
      hold = thr_reg + 1 + $urandom_range(0, 2);
    end else if (pick == 7) begin
      target = 14'($urandom);
      hold   = $urandom_range(0, thr_reg);
    end else if (pick == 8) begin
      target = prev_scan;
      hold   = $urandom_range(0, 3);
    end else begin
      target = 14'($urandom);
      hold   = 0;
    end
    for (n = 0; n <= hold; n++) begin
      send_scan(target, 1'b0, '0);
      pace_sender();
    end
  endtask

  // Result side: random stalls, one long hold-off on request, none when calm.
  initial begin : sink
    int n;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_ev.kind = ev_kind_t'(out_tdata[1:0]);
      got_ev.note = out_tdata[8:2];
      got_ev.vel  = out_tdata[15:9];
      got_ev.down = out_tdata[21:16];
      got_ev.up   = out_tdata[27:22];
      got_ev.last = out_tlast;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with no event expected", beats_checked));
      end else begin
        want_ev = pending_events.pop_front();
        check_field("event_kind", got_ev.kind, want_ev.kind);
        check_field("note_number", got_ev.note, want_ev.note);
        check_field("velocity", got_ev.vel, want_ev.vel);
        check_field("down_led_level", got_ev.down, want_ev.down);
        check_field("up_led_level", got_ev.up, want_ev.up);
        check_field("last", got_ev.last, want_ev.last);
      end
      beats_checked++;
    end
  end

  initial begin
    #(longint'(LIMIT_CYCLES) * 2 * HALF_PERIOD_NS);
    $display("Run stopped: no progress within the cycle limit.");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int s;
    int rep;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_IDX_THRESHOLD;
    cfg_wdata  <= '0;
    prev_scan  = '0;
    sent_keys  = '0;
    stable_cnt = '0;
    thr_reg    = THRESH_RESET;
    vel_reg    = VEL_RESET;
    oct_reg    = OCT_RESET;
    cur_oct    = OCT_RESET;

    // The first row runs on the reset registers: 51 equal scans after a change.
    add_checked(14'h0001, 52, mk_event(EV_NOTE_ON, 60, 100, 0, 0));
    add_cfg(CFG_IDX_THRESHOLD, 8'd0);
    add_checked(14'h0000, 2, mk_event(EV_NOTE_OFF, 60, 0, 0, 0));
    add_scan(14'h0FFF, 2);
    add_scan(14'h0000, 2);
    add_checked(OCT_DOWN_KEY, 2, mk_event(EV_OCTAVE, 0, 0, 20, 0));
    add_cfg(CFG_IDX_OCTAVE, 8'd24);
    add_scan(14'h0000, 2);
    add_checked(OCT_DOWN_KEY, 2, mk_event(EV_OCTAVE, 0, 0, 60, 0));
    add_checked(OCT_UP_KEY, 2, mk_event(EV_OCTAVE, 0, 0, 40, 0));
    add_cfg(CFG_IDX_OCTAVE, 8'd96);
    add_scan(14'h0000, 2);
    add_checked(OCT_UP_KEY, 2, mk_event(EV_OCTAVE, 0, 0, 0, 60));
    add_scan(ALL_KEYS, 2);
    add_cfg(CFG_IDX_VELOCITY, 8'd0);
    add_checked(14'h3FFE, 2, mk_event(EV_NOTE_OFF, 84, 0, 0, 0));
    add_checked(ALL_KEYS, 2, mk_event(EV_NOTE_ON, 84, 0, 0, 0));
    add_cfg(CFG_IDX_VELOCITY, 8'd127);
    add_cfg(CFG_IDX_OCTAVE, 8'd0);
    add_checked(14'h3FFE, 2, mk_event(EV_NOTE_OFF, 24, 0, 0, 0));
    add_cfg(CFG_IDX_OCTAVE, 8'd127);
    add_checked(ALL_KEYS, 2, mk_event(EV_NOTE_ON, 96, 127, 0, 0));
    add_cfg(CFG_IDX_OCTAVE, 8'd61);
    add_scan(14'h0000, 2);
    // An octave off the grid of twelve lights neither indicator.
    add_checked(OCT_DOWN_KEY, 2, mk_event(EV_OCTAVE, 0, 0, 0, 0));
    add_cfg(CFG_IDX_SPARE, 8'hFF);
    add_cfg(CFG_IDX_THRESHOLD, 8'd2);
    add_scan(14'h0001, 2);
    add_checked(14'h0002, 4, mk_event(EV_NOTE_ON, 50, 127, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        settle();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        for (rep = 0; rep < plan[r].reps; rep++) begin
          send_scan(plan[r].mask, plan[r].typed && rep == plan[r].reps - 1, plan[r].ev);
          pace_sender();
        end
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(CFG_IDX_THRESHOLD, 8'(phase_thr[ph]));
      write_reg(CFG_IDX_VELOCITY, 8'(phase_vel[ph]));
      write_reg(CFG_IDX_OCTAVE, 8'(phase_oct[ph]));
      calm  = (ph == NUM_PHASES - 1);
      gappy = (ph != 0) && ($urandom_range(0, 3) != 0);
      // In the first phase the sender keeps going while the result side holds off.
      if (ph == 0) hold_off_req = 1'b1;
      for (s = 0; s < phase_seqs[ph]; s++) run_sequence();
    end

    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    end

    $display("Covered %0d key scans over a directed table and %0d register phases, %0d writes.",
             scans_sent, NUM_PHASES, cfg_writes);
    $display("Compared %0d note and octave events field by field; %0d mismatches.",
             beats_checked, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
